/* design/quaternion_smallest_three_encoder_top_macros.svh */
// Assertion macros used by the smallest-three encoder top level
`ifndef QUATERNION_SMALLEST_THREE_ENCODER_TOP_MACROS_SVH
`define QUATERNION_SMALLEST_THREE_ENCODER_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define S3E_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s3e implication check failed");

// Check that a condition never holds
`define S3E_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("s3e forbidden condition seen");

`endif

/* design/s3e_pkg.sv */
// Shared types, constants and functions of the smallest-three encoder
package s3e_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int SQ_W       = 2 * COMP_WIDTH - 1;
    localparam int SUM_W      = 2 * COMP_WIDTH + 1;
    localparam int ADSQ_W     = 16;
    localparam int HALF_W     = 17;
    localparam int RHS_W      = SQ_W + HALF_W;
    localparam int CMP_W      = SUM_W + ADSQ_W;
    localparam int CODE_W     = 8;
    localparam int SEARCH_STAGES = CODE_W;

    localparam logic [HALF_W-1:0] HALF_SCALE_SQ2 = 17'd130050;
    localparam logic [7:0]        TAG_BASE       = 8'd252;
    localparam logic [7:0]        DEGEN_CODE     = 8'd127;

    typedef logic [1:0] keep_tab_t [4][3];
    localparam keep_tab_t KEEP_TABLE = '{
        '{2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd3},
        '{2'd0, 2'd1, 2'd2}
    };

    typedef logic [ADSQ_W-1:0] adsq_tab_t [256];

    // Square of |2k - 255| for every code k
    function automatic adsq_tab_t build_adsq();
        adsq_tab_t t;
        int d;
        for (int i = 0; i < 256; i++)
        begin
            d = 2 * i - 255;
            if (d < 0)
                d = -d;
            t[i] = ADSQ_W'(d * d);
        end
        return t;
    endfunction

    localparam adsq_tab_t ADSQ_TABLE = build_adsq();

    // Control that travels with each request
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [1:0] big;
    } ctl_t;

    // One kept component after sign fix-up
    typedef struct packed {
        logic             neg;
        logic             nil;
        logic [RHS_W-1:0] rhs;
    } kept_t;

    // Decide whether code cand still lies at or below the exact value
    function automatic logic fits(logic [7:0] cand, logic vneg, logic vnil,
                                  logic [SUM_W-1:0] sumsq, logic [RHS_W-1:0] rhs);
        logic             dneg;
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhsx;
        logic             res;
        dneg = ~cand[7];
        lhs  = CMP_W'(sumsq) * CMP_W'(ADSQ_TABLE[cand]);
        rhsx = CMP_W'(rhs);
        if (dneg && !vneg)
            res = 1'b1;
        else if (!dneg && (vneg || vnil))
            res = 1'b0;
        else if (!dneg)
            res = (lhs <= rhsx);
        else
            res = (lhs >= rhsx);
        return res;
    endfunction

endpackage

/* design/s3e_front.sv */
// Front stages: magnitudes, squares, largest pick, length and right-hand sides
module s3e_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_zero,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_one,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_two,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_three,
    output s3e_pkg::ctl_t                      ctl,
    output logic [s3e_pkg::SUM_W-1:0]          sumsq,
    output s3e_pkg::kept_t [2:0]               kept
);

    localparam int W = s3e_pkg::COMP_WIDTH;

    // stage 1: input capture
    logic [W-1:0] comp_reg [4];
    logic         v1_reg;

    // stage 2: magnitude and square
    logic [W-1:0]             mag_reg [4];
    logic [s3e_pkg::SQ_W-1:0] sq_reg [4];
    logic [3:0]               qneg_reg;
    logic                     v2_reg;
    logic [W-1:0]             mag_next [4];
    logic [s3e_pkg::SQ_W-1:0] sq_next [4];

    // stage 3: pick largest, select kept, sum squares
    s3e_pkg::ctl_t              ctl3_reg;
    s3e_pkg::ctl_t              ctl3_next;
    logic [s3e_pkg::SUM_W-1:0]  sum3_reg;
    logic [s3e_pkg::SUM_W-1:0]  sum3_next;
    logic [2:0]                 kneg3_reg, kneg3_next;
    logic [2:0]                 knil3_reg, knil3_next;
    logic [s3e_pkg::SQ_W-1:0]   ksq3_reg [3];
    logic [s3e_pkg::SQ_W-1:0]   ksq3_next [3];

    // stage 4: scaled right-hand sides
    s3e_pkg::ctl_t              ctl4_reg;
    logic [s3e_pkg::SUM_W-1:0]  sum4_reg;
    s3e_pkg::kept_t [2:0]       kept4_reg;
    s3e_pkg::kept_t [2:0]       kept4_next;

    // capture request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        comp_reg[0] <= comp_zero;
        comp_reg[1] <= comp_one;
        comp_reg[2] <= comp_two;
        comp_reg[3] <= comp_three;
    end

    // take magnitudes and squares
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_next[i] = comp_reg[i][W-1] ? (~comp_reg[i] + W'(1)) : comp_reg[i];
            sq_next[i]  = s3e_pkg::SQ_W'(mag_next[i]) * s3e_pkg::SQ_W'(mag_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_reg[i]  <= mag_next[i];
            sq_reg[i]   <= sq_next[i];
            qneg_reg[i] <= comp_reg[i][W-1];
        end
    end

    // pick the largest, lowest index on ties, and select the kept three
    always_comb
    begin
        logic [1:0] big;
        logic [1:0] idx;
        logic       flip;
        big = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (mag_reg[i] > mag_reg[big])
                big = 2'(i);
        end
        flip = qneg_reg[big];
        ctl3_next.valid = v2_reg;
        ctl3_next.zero  = (mag_reg[0] == '0) && (mag_reg[1] == '0) &&
                          (mag_reg[2] == '0) && (mag_reg[3] == '0);
        ctl3_next.big   = big;
        sum3_next = s3e_pkg::SUM_W'(sq_reg[0]) + s3e_pkg::SUM_W'(sq_reg[1]) +
                    s3e_pkg::SUM_W'(sq_reg[2]) + s3e_pkg::SUM_W'(sq_reg[3]);
        for (int j = 0; j < 3; j++)
        begin
            idx           = s3e_pkg::KEEP_TABLE[big][j];
            knil3_next[j] = (mag_reg[idx] == '0);
            kneg3_next[j] = (qneg_reg[idx] ^ flip) && !knil3_next[j];
            ksq3_next[j]  = sq_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl3_reg <= '0;
        else
            ctl3_reg <= ctl3_next;
    end

    always_ff @(posedge clk)
    begin
        sum3_reg  <= sum3_next;
        kneg3_reg <= kneg3_next;
        knil3_reg <= knil3_next;
        for (int j = 0; j < 3; j++)
            ksq3_reg[j] <= ksq3_next[j];
    end

    // scale each kept square by twice 255 squared
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            kept4_next[j].neg = kneg3_reg[j];
            kept4_next[j].nil = knil3_reg[j];
            kept4_next[j].rhs = s3e_pkg::RHS_W'(ksq3_reg[j]) *
                                s3e_pkg::RHS_W'(s3e_pkg::HALF_SCALE_SQ2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl4_reg <= '0;
        else
            ctl4_reg <= ctl3_reg;
    end

    always_ff @(posedge clk)
    begin
        sum4_reg  <= sum3_reg;
        kept4_reg <= kept4_next;
    end

    assign ctl   = ctl4_reg;
    assign sumsq = sum4_reg;
    assign kept  = kept4_reg;

endmodule

/* design/s3e_search.sv */
// Bit-per-stage search of the three output codes, most significant bit first
module s3e_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  s3e_pkg::ctl_t                     ctl_in,
    input  logic [s3e_pkg::SUM_W-1:0]         sumsq_in,
    input  s3e_pkg::kept_t [2:0]              kept_in,
    output s3e_pkg::ctl_t                     ctl_out,
    output logic [2:0][s3e_pkg::CODE_W-1:0]   code_out
);

    localparam int N = s3e_pkg::SEARCH_STAGES;

    s3e_pkg::ctl_t                   ctl_reg   [1:N];
    logic [s3e_pkg::SUM_W-1:0]       sumsq_reg [1:N];
    s3e_pkg::kept_t [2:0]            kept_reg  [1:N];
    logic [2:0][s3e_pkg::CODE_W-1:0] code_reg  [1:N];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam logic [s3e_pkg::CODE_W-1:0] BIT_MASK =
            s3e_pkg::CODE_W'(1) << (N - 1 - s);

        s3e_pkg::ctl_t                   ctl_cur;
        logic [s3e_pkg::SUM_W-1:0]       sumsq_cur;
        s3e_pkg::kept_t [2:0]            kept_cur;
        logic [2:0][s3e_pkg::CODE_W-1:0] code_cur;
        logic [2:0][s3e_pkg::CODE_W-1:0] code_next;

        // first stage takes the incoming request with an empty code
        if (s == 0)
        begin : g_head
            assign ctl_cur   = ctl_in;
            assign sumsq_cur = sumsq_in;
            assign kept_cur  = kept_in;
            assign code_cur  = '0;
        end
        else
        begin : g_body
            assign ctl_cur   = ctl_reg[s];
            assign sumsq_cur = sumsq_reg[s];
            assign kept_cur  = kept_reg[s];
            assign code_cur  = code_reg[s];
        end

        // try one more bit on each kept component
        always_comb
        begin
            logic [s3e_pkg::CODE_W-1:0] cand;
            for (int j = 0; j < 3; j++)
            begin
                cand = code_cur[j] | BIT_MASK;
                code_next[j] = s3e_pkg::fits(cand, kept_cur[j].neg, kept_cur[j].nil,
                                             sumsq_cur, kept_cur[j].rhs)
                               ? cand : code_cur[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s+1] <= '0;
            else
                ctl_reg[s+1] <= ctl_cur;
        end

        always_ff @(posedge clk)
        begin
            sumsq_reg[s+1] <= sumsq_cur;
            kept_reg[s+1]  <= kept_cur;
            code_reg[s+1]  <= code_next;
        end
    end

    assign ctl_out  = ctl_reg[N];
    assign code_out = code_reg[N];

endmodule

/* design/quaternion_smallest_three_encoder_top.sv */
// Top level of the smallest-three quaternion encoder, 8 bits per kept component
//
//  channel | direction | handshake     | fields
//  request | in        | start / busy  | comp_zero, comp_one, comp_two, comp_three
//  result  | out       | done strobe   | packed_first, packed_second, packed_third,
//          |           |               | largest_tag, degenerate
//
// One request enters every cycle. Each request passes through four front stages, one
// search stage per code bit and the output register. busy stays low: results are
// strobed for one cycle and the receiver cannot stall. Reset clears all valid bits;
// data registers are not reset.
`include "quaternion_smallest_three_encoder_top_macros.svh"

module quaternion_smallest_three_encoder_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_zero,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_one,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_two,
    input  logic signed [s3e_pkg::COMP_WIDTH-1:0] comp_three,
    output logic                                  done,
    output logic [7:0]                            packed_first,
    output logic [7:0]                            packed_second,
    output logic [7:0]                            packed_third,
    output logic [7:0]                            largest_tag,
    output logic                                  degenerate
);

    localparam int LATENCY = 13;

    s3e_pkg::ctl_t                   front_ctl;
    logic [s3e_pkg::SUM_W-1:0]       front_sumsq;
    s3e_pkg::kept_t [2:0]            front_kept;
    s3e_pkg::ctl_t                   srch_ctl;
    logic [2:0][s3e_pkg::CODE_W-1:0] srch_code;

    logic       done_reg;
    logic [7:0] first_reg, second_reg, third_reg, tag_reg;
    logic       degen_reg;

    s3e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .comp_zero  (comp_zero),
        .comp_one   (comp_one),
        .comp_two   (comp_two),
        .comp_three (comp_three),
        .ctl        (front_ctl),
        .sumsq      (front_sumsq),
        .kept       (front_kept)
    );

    s3e_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (front_ctl),
        .sumsq_in (front_sumsq),
        .kept_in  (front_kept),
        .ctl_out  (srch_ctl),
        .code_out (srch_code)
    );

    // strobe the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= srch_ctl.valid;
    end

    // substitute fixed codes for an all-zero request
    always_ff @(posedge clk)
    begin
        first_reg  <= srch_ctl.zero ? s3e_pkg::DEGEN_CODE : srch_code[0];
        second_reg <= srch_ctl.zero ? s3e_pkg::DEGEN_CODE : srch_code[1];
        third_reg  <= srch_ctl.zero ? s3e_pkg::DEGEN_CODE : srch_code[2];
        tag_reg    <= s3e_pkg::TAG_BASE + 8'(srch_ctl.big);
        degen_reg  <= srch_ctl.zero;
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign packed_first  = first_reg;
    assign packed_second = second_reg;
    assign packed_third  = third_reg;
    assign largest_tag   = tag_reg;
    assign degenerate    = degen_reg;

    `S3E_ASSERT_IMPLY(a_done_follows_start, done, $past(start, LATENCY))
    `S3E_ASSERT_IMPLY(a_degen_codes, done && degenerate,
        packed_first == s3e_pkg::DEGEN_CODE && packed_second == s3e_pkg::DEGEN_CODE &&
        packed_third == s3e_pkg::DEGEN_CODE && largest_tag == s3e_pkg::TAG_BASE)
    `S3E_ASSERT_NEVER(a_tag_range, done && largest_tag < s3e_pkg::TAG_BASE)

endmodule

/* test/quaternion_smallest_three_encoder_top_test.sv */
// Testbench for the smallest-three quaternion encoder: random and directed requests, exact check
module quaternion_smallest_three_encoder_top_test;

    localparam int CW = s3e_pkg::COMP_WIDTH;

    typedef struct {
        logic signed [CW-1:0] c [4];
        bit                   hold;
    } req_t;

    typedef struct {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] tag;
        logic       degen;
    } code_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] comp_zero;
    logic signed [CW-1:0] comp_one;
    logic signed [CW-1:0] comp_two;
    logic signed [CW-1:0] comp_three;
    logic                 done;
    logic [7:0]           packed_first;
    logic [7:0]           packed_second;
    logic [7:0]           packed_third;
    logic [7:0]           largest_tag;
    logic                 degenerate;

    req_t  pending_q [$];
    code_t codes_q [$];
    int    mismatches;
    int    sent;
    int    got;
    int    gap;
    bit    stim_done;

    quaternion_smallest_three_encoder_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .comp_zero(comp_zero), .comp_one(comp_one), .comp_two(comp_two),
        .comp_three(comp_three), .done(done), .packed_first(packed_first),
        .packed_second(packed_second), .packed_third(packed_third),
        .largest_tag(largest_tag), .degenerate(degenerate)
    );

    // Toggle the clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Largest k with (2k-255)*len <= 255*sqrt2*v, decided on squares
    function automatic logic [7:0] quantize(longint v, logic [127:0] sumsq);
        logic [7:0]   k;
        logic [8:0]   cand;
        int           d;
        logic [127:0] lhs;
        logic [127:0] rhs;
        bit           ok;
        longint       av;
        k = 8'd0;
        av = (v < 0) ? -v : v;
        for (int b = 7; b >= 0; b--)
        begin
            cand = {1'b0, k} | (9'd1 << b);
            d = 2 * int'(cand) - 255;
            lhs = sumsq * 128'(d * d);
            rhs = 128'(av) * 128'(av) * 128'd130050;
            if (d < 0 && v >= 0)
                ok = 1'b1;
            else if (d > 0 && v <= 0)
                ok = 1'b0;
            else if (d > 0)
                ok = (lhs <= rhs);
            else
                ok = (lhs >= rhs);
            if (ok)
                k = cand[7:0];
        end
        return k;
    endfunction

    // Encode one quaternion
    function automatic code_t encode_quat(req_t r);
        code_t        e;
        longint       q [4];
        longint       m [4];
        logic [127:0] sumsq;
        int           big;
        logic [7:0]   bytes [3];
        int           j;
        sumsq = '0;
        big = 0;
        for (int i = 0; i < 4; i++)
        begin
            q[i] = longint'(r.c[i]);
            m[i] = (q[i] < 0) ? -q[i] : q[i];
            sumsq += 128'(m[i] * m[i]);
        end
        if (sumsq == 0)
        begin
            e.b0 = 8'd127; e.b1 = 8'd127; e.b2 = 8'd127;
            e.tag = s3e_pkg::TAG_BASE; e.degen = 1'b1;
            return e;
        end
        for (int i = 1; i < 4; i++)
            if (m[i] > m[big])
                big = i;
        if (q[big] < 0)
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
        j = 0;
        for (int i = 0; i < 4; i++)
            if (i != big)
            begin
                bytes[j] = quantize(q[i], sumsq);
                j++;
            end
        e.b0 = bytes[0]; e.b1 = bytes[1]; e.b2 = bytes[2];
        e.tag = s3e_pkg::TAG_BASE + 8'(big);
        e.degen = 1'b0;
        return e;
    endfunction

    task automatic report(string what, int got_v, int exp_v);
        $display("mismatch on %s: got %0d expected %0d", what, got_v, exp_v);
        mismatches++;
    endtask

    task automatic add_req(int a, int b, int c, int d);
        req_t r;
        r.c[0] = CW'(a); r.c[1] = CW'(b); r.c[2] = CW'(c); r.c[3] = CW'(d);
        r.hold = 1'b0;
        pending_q.push_back(r);
    endtask

    function automatic int rand_comp(int scale);
        int v;
        case (scale)
            0: v = $urandom_range(65535) - 32768;
            1: v = $urandom_range(255) - 128;
            2: v = $urandom_range(7) - 4;
            default: v = ($urandom_range(1) ? 32767 : -32768) - $urandom_range(3);
        endcase
        return v;
    endfunction

    // Fill the queue: directed cases, then random quaternions
    initial
    begin
        req_t r;
        int   s;
        mismatches = 0;
        stim_done = 1'b0;
        add_req(0, 0, 0, 0);
        add_req(-32768, -32768, -32768, -32768);
        add_req(32767, 32767, 32767, 32767);
        add_req(-32768, 0, 0, 0);
        add_req(0, -32768, 0, 0);
        add_req(0, 0, -32768, 0);
        add_req(0, 0, 0, -32768);
        add_req(0, 0, 0, 1);
        add_req(1, 0, 0, -1);
        add_req(-1, 1, 0, 0);
        add_req(100, 100, 0, 0);
        add_req(-100, 100, 0, 0);
        add_req(-100, -100, 0, 0);
        add_req(5, -7, 3, 7);
        add_req(32767, -32768, 32767, 0);
        add_req(-32767, 32767, -32767, 32767);
        add_req(1, 1, 1, 1);
        add_req(-1, -1, -1, -1);
        add_req(0, 1, 2, 3);
        add_req(-3, 2, -1, 0);
        for (int n = 0; n < 1100; n++)
        begin
            s = $urandom_range(3);
            for (int i = 0; i < 4; i++)
                r.c[i] = CW'(rand_comp(($urandom_range(3) == 0) ? $urandom_range(3) : s));
            if ($urandom_range(9) == 0)
            begin
                s = $urandom_range(3);
                r.c[s] = r.c[(s + 1) % 4];
            end
            r.hold = (n == 500);
            pending_q.push_back(r);
        end
        stim_done = 1'b1;
    end

    // Reset once at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: issue requests on the falling edge
    initial
    begin
        start = 1'b0;
        comp_zero = '0; comp_one = '0; comp_two = '0; comp_three = '0;
        sent = 0;
        gap = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            if (gap > 0)
            begin
                gap <= gap - 1;
                start <= 1'b0;
            end
            else if (pending_q.size() > 0 && !(pending_q[0].hold && codes_q.size() > 0))
            begin
                req_t r;
                r = pending_q.pop_front();
                comp_zero <= r.c[0]; comp_one <= r.c[1];
                comp_two <= r.c[2]; comp_three <= r.c[3];
                start <= 1'b1;
                codes_q.push_back(encode_quat(r));
                sent++;
                gap <= ($urandom_range(2) == 0) ? 0 : $urandom_range(8);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        code_t e;
        if (rst_n && done)
        begin
            if (codes_q.size() == 0)
            begin
                $display("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                e = codes_q.pop_front();
                got++;
                if (packed_first !== e.b0) report("packed_first", packed_first, e.b0);
                if (packed_second !== e.b1) report("packed_second", packed_second, e.b1);
                if (packed_third !== e.b2) report("packed_third", packed_third, e.b2);
                if (largest_tag !== e.tag) report("largest_tag", largest_tag, e.tag);
                if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
            end
        end
    end

    // Drain and finish
    initial
    begin
        got = 0;
        wait (stim_done);
        wait (pending_q.size() == 0 && codes_q.size() == 0);
        repeat (40) @(posedge clk);
        if (codes_q.size() != 0)
            mismatches++;
        $display("covered %0d requests, %0d results checked", sent, got);
        if (mismatches == 0)
            $display("quaternion_smallest_three_encoder_top_test: done, clean");
        else
            $display("quaternion_smallest_three_encoder_top_test: done, errors");
        $finish;
    end

    // Give up after a generous bound
    initial
    begin
        #2000000;
        $display("timeout waiting for results");
        $display("quaternion_smallest_three_encoder_top_test: done, errors");
        $finish;
    end

endmodule
